// ----- rtl/core/rti_pkg.sv -----
package rti_pkg;

  localparam int DataW    = 64;
  localparam int CntW     = $clog2(DataW);
  localparam int IndexW   = 64;
  localparam int WordBits = 64;
  localparam int ShiftW   = $clog2(WordBits);

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_REDUCED = 2'd1,
    ST_NO_INDEX    = 2'd2
  } status_e;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quot;
    logic [DataW-1:0] rem;
  } div_res_t;

  typedef struct packed {
    logic clear;
    logic emit;
    logic flip;
  } run_cmd_t;

  typedef struct packed {
    logic [IndexW-1:0] cw;
    logic [IndexW-1:0] sb;
    logic [ShiftW-1:0] shift;
  } run_res_t;

endpackage

// ----- rtl/core/rti_div.sv -----
module rti_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rti_pkg::div_req_t req_i,
  output rti_pkg::div_res_t res_o
);
  import rti_pkg::*;

  typedef enum logic [2:0] {
    D_IDLE  = 3'b001,
    D_ALIGN = 3'b010,
    D_DIV   = 3'b100
  } dstate_e;

  dstate_e          state_q, state_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quot_q, quot_d;
  logic [DataW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DataW-1:0] dvs_up;
  logic             can_align;
  logic             ge;

  assign dvs_up    = {dvs_q[DataW-2:0], 1'b0};
  assign can_align = !dvs_q[DataW-1] && (dvs_up <= rem_q);
  assign ge        = rem_q >= dvs_q;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          rem_d   = req_i.dividend;
          dvs_d   = req_i.divisor;
          quot_d  = '0;
          cnt_d   = '0;
          state_d = D_ALIGN;
        end
      end
      D_ALIGN: begin
        if (can_align) begin
          dvs_d = dvs_up;
          cnt_d = cnt_q + 1'b1;
        end else begin
          state_d = D_DIV;
        end
      end
      D_DIV: begin
        if (ge) begin
          rem_d = rem_q - dvs_q;
        end
        quot_d = {quot_q[DataW-2:0], ge};
        dvs_d  = {1'b0, dvs_q[DataW-1:1]};
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = D_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q;

endmodule

// ----- rtl/core/rti_run.sv -----
module rti_run (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rti_pkg::run_cmd_t cmd_i,
  output rti_pkg::run_res_t res_o
);
  import rti_pkg::*;

  logic [IndexW-1:0] cw_q, cw_d;
  logic [IndexW-1:0] sb_q, sb_d;
  logic [ShiftW-1:0] shift_q, shift_d;
  logic              ones_q, ones_d;

  always_comb begin
    cw_d    = cw_q;
    sb_d    = sb_q;
    shift_d = shift_q;
    ones_d  = ones_q;
    if (cmd_i.clear) begin
      cw_d    = '0;
      sb_d    = IndexW'(1);
      shift_d = '0;
      ones_d  = 1'b1;
    end else begin
      if (cmd_i.emit) begin
        cw_d[shift_q] = ones_q;
        sb_d          = {sb_q[IndexW-2:0], ones_q};
        shift_d       = shift_q + 1'b1;
      end
      if (cmd_i.flip) begin
        ones_d = !ones_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      ones_q  <= 1'b1;
    end else begin
      shift_q <= shift_d;
      ones_q  <= ones_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cw_q <= cw_d;
    sb_q <= sb_d;
  end

  assign res_o.cw    = cw_q | (IndexW'(1) << shift_q);
  assign res_o.sb    = sb_q;
  assign res_o.shift = shift_q;

endmodule

// ----- rtl/core/rational_tree_index.sv -----
// When a part is zero the item goes straight to the result; otherwise each Euclid
// quotient comes from the shift-subtract divider and, if it fits, its run of index
// bits is emitted by the index builder.
// Throughput: one item at a time, set by the single shared divider and the
// one-bit-per-cycle index builder; a new item is taken while a result waits.
// Reset is asynchronous and active low and clears all control state.
module rational_tree_index (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [rti_pkg::DataW-1:0] numerator_i,
  input  logic [rti_pkg::DataW-1:0] denominator_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rti_pkg::IndexW-1:0] cw_index_o,
  output logic [rti_pkg::IndexW-1:0] sb_index_o,
  output logic [1:0]                status_o
);
  import rti_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_CHECK = 6'b000100,
    S_RUN   = 6'b001000,
    S_NEXT  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [DataW-1:0]  b_q, b_d;
  logic [ShiftW-1:0] run_q, run_d;
  logic              ovf_q, ovf_d;
  status_e           res_st_q, res_st_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [IndexW-1:0] cw_q, cw_d;
  logic [IndexW-1:0] sb_q, sb_d;

  div_req_t          div_req;
  div_res_t          div_res;
  run_cmd_t          run_cmd;
  run_res_t          run_res;

  logic              accept;
  logic [DataW-1:0]  len;
  logic [ShiftW:0]   room;
  logic              too_long;
  logic              out_free;

  rti_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  rti_run u_run (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (run_cmd),
    .res_o  (run_res)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign len      = div_res.quot - DataW'(div_res.rem == '0);
  assign room     = (ShiftW + 1)'(WordBits) - {1'b0, run_res.shift};
  assign too_long = len >= DataW'(room);

  always_comb begin
    state_d          = state_q;
    b_d              = b_q;
    run_d            = run_q;
    ovf_d            = ovf_q;
    res_st_d         = res_st_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    status_d         = status_q;
    cw_d             = cw_q;
    sb_d             = sb_q;
    div_req.start    = 1'b0;
    div_req.dividend = numerator_i;
    div_req.divisor  = denominator_i;
    run_cmd          = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (numerator_i == '0 || denominator_i == '0) begin
            res_st_d = ST_NO_INDEX;
            state_d  = S_DONE;
          end else begin
            b_d           = denominator_i;
            ovf_d         = 1'b0;
            run_cmd.clear = 1'b1;
            div_req.start = 1'b1;
            state_d       = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (ovf_q || too_long) begin
          ovf_d   = 1'b1;
          state_d = S_NEXT;
        end else begin
          run_d   = len[ShiftW-1:0];
          state_d = (len == '0) ? S_NEXT : S_RUN;
        end
      end
      S_RUN: begin
        run_cmd.emit = 1'b1;
        run_d        = run_q - 1'b1;
        if (run_q == ShiftW'(1)) begin
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        run_cmd.flip = 1'b1;
        if (div_res.rem == '0) begin
          if (b_q != DataW'(1)) begin
            res_st_d = ST_NOT_REDUCED;
          end else if (ovf_q) begin
            res_st_d = ST_NO_INDEX;
          end else begin
            res_st_d = ST_OK;
          end
          state_d = S_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = b_q;
          div_req.divisor  = div_res.rem;
          b_d              = div_res.rem;
          state_d          = S_DIV;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = res_st_q;
          cw_d        = (res_st_q == ST_OK) ? run_res.cw : '0;
          sb_d        = (res_st_q == ST_OK) ? run_res.sb : '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_q       <= '0;
      ovf_q       <= 1'b0;
      res_st_q    <= ST_OK;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      ovf_q       <= ovf_d;
      res_st_q    <= res_st_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q  <= b_d;
    cw_q <= cw_d;
    sb_q <= sb_d;
  end

  assign out_valid_o = out_valid_q;
  assign cw_index_o  = cw_q;
  assign sb_index_o  = sb_q;
  assign status_o    = status_q;

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN |-> run_q != '0)
    else $error("run counter empty while emitting index bits");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == S_DIV)
    else $error("divider finished while control was not waiting for it");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> cw_index_o == '0 && sb_index_o == '0)
    else $error("failed item carries a nonzero index");

  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |-> cw_index_o != '0 && sb_index_o != '0)
    else $error("successful item carries a zero index");

  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("control state lost its one-hot code");

endmodule

// ----- dv/rational_tree_index_tb.sv -----
`timescale 1ns / 100ps

module rational_tree_index_tb;
  import rti_pkg::*;

  localparam int RandomItems = 1800;
  localparam int StuckLimit  = 5000;
  localparam int DrainCycles = 500;

  typedef struct {
    logic [DataW-1:0]  num;
    logic [DataW-1:0]  den;
    logic [IndexW-1:0] cw;
    logic [IndexW-1:0] sb;
    status_e           status;
  } tree_pos_t;

  typedef struct {
    logic [DataW-1:0] num;
    logic [DataW-1:0] den;
    bit               typed;
    tree_pos_t        pos;
  } fraction_row_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [DataW-1:0]   numerator_i   = '0;
  logic [DataW-1:0]   denominator_i = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [IndexW-1:0]  cw_index_o;
  logic [IndexW-1:0]  sb_index_o;
  logic [1:0]         status_o;

  bit                 row_typed     = 1'b0;
  tree_pos_t          row_pos;
  tree_pos_t          pending_positions[$];
  int                 error_count   = 0;
  int                 offered_count = 0;

  rational_tree_index dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .numerator_i   (numerator_i),
    .denominator_i (denominator_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cw_index_o    (cw_index_o),
    .sb_index_o    (sb_index_o),
    .status_o      (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Euclid's quotients give the run lengths of the Calkin-Wilf index, least
  // significant run first; the Stern-Brocot index mirrors the bits below the top one.
  function automatic tree_pos_t locate_fraction(logic [DataW-1:0] num, logic [DataW-1:0] den);
    tree_pos_t         pos;
    logic [DataW-1:0]  a;
    logic [DataW-1:0]  b;
    logic [DataW-1:0]  r;
    logic [DataW-1:0]  len;
    logic [DataW-1:0]  quotients[$];
    logic [IndexW-1:0] cw;
    logic [IndexW-1:0] m;
    int                filled;
    bit                ones;
    pos.num    = num;
    pos.den    = den;
    pos.cw     = '0;
    pos.sb     = '0;
    pos.status = ST_OK;
    if (num == 0 || den == 0) begin
      pos.status = ST_NO_INDEX;
      return pos;
    end
    a = num;
    b = den;
    while (b != 0) begin
      quotients.push_back(a / b);
      r = a % b;
      a = b;
      b = r;
    end
    if (a != 1) begin
      pos.status = ST_NOT_REDUCED;
      return pos;
    end
    quotients[quotients.size() - 1] -= 1;
    cw     = '0;
    filled = 0;
    ones   = 1'b1;
    foreach (quotients[i]) begin
      len = quotients[i];
      if (len >= 64'(WordBits - filled)) begin
        pos.status = ST_NO_INDEX;
        return pos;
      end
      if (ones && len != 0) cw |= ((64'd1 << len) - 64'd1) << filled;
      filled += int'(len);
      ones = !ones;
    end
    cw |= 64'd1 << filled;
    pos.cw = cw;
    pos.sb = 64'd1;
    m = cw;
    while (m > 1) begin
      pos.sb = {pos.sb[IndexW-2:0], m[0]};
      m = m >> 1;
    end
    return pos;
  endfunction

  function automatic fraction_row_t fraction_row(logic [DataW-1:0] num, logic [DataW-1:0] den,
                                                 bit typed = 1'b0,
                                                 logic [IndexW-1:0] cw = '0,
                                                 logic [IndexW-1:0] sb = '0,
                                                 status_e st = ST_OK);
    fraction_row_t row;
    row.num        = num;
    row.den        = den;
    row.typed      = typed;
    row.pos.num    = num;
    row.pos.den    = den;
    row.pos.cw     = cw;
    row.pos.sb     = sb;
    row.pos.status = st;
    return row;
  endfunction

  // Every fourth stretch of 128 items runs without any idle cycles.
  function automatic int draw_gap(int count);
    if ((count / 128) % 4 == 3) return 0;
    if ($urandom_range(3, 0) == 0) return 0;
    return $urandom_range(18, 0);
  endfunction

  task automatic offer_fraction(fraction_row_t row);
    int gap;
    gap = draw_gap(offered_count);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    numerator_i   <= row.num;
    denominator_i <= row.den;
    row_typed     <= row.typed;
    row_pos       <= row.pos;
    do @(posedge clk_i); while (!in_ready_o);
    offered_count++;
  endtask

  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_positions.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int taken;
    int stall;
    taken = 0;
    @(posedge clk_i);
    forever begin
      stall = draw_gap(taken);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  always @(posedge clk_i) begin
    tree_pos_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (row_typed) pending_positions.push_back(row_pos);
        else pending_positions.push_back(locate_fraction(numerator_i, denominator_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_positions.size() == 0) begin
          $display("%0t: unexpected result, expected none, got cw %h sb %h status %0d",
                   $time, cw_index_o, sb_index_o, status_o);
          error_count++;
        end else begin
          want = pending_positions.pop_front();
          if (cw_index_o !== want.cw) begin
            $display("%0t: cw_index for %0d/%0d expected %h, got %h",
                     $time, want.num, want.den, want.cw, cw_index_o);
            error_count++;
          end
          if (sb_index_o !== want.sb) begin
            $display("%0t: sb_index for %0d/%0d expected %h, got %h",
                     $time, want.num, want.den, want.sb, sb_index_o);
            error_count++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status for %0d/%0d expected %0d, got %0d",
                     $time, want.num, want.den, want.status, status_o);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    int stuck_cycles;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, StuckLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    fraction_row_t    rows[$];
    fraction_row_t    item;
    logic [DataW-1:0] num;
    logic [DataW-1:0] den;
    logic [DataW-1:0] path;
    int               depth;
    int               kind;
    int               scale;

    rows.push_back(fraction_row(64'd1, 64'd1, 1'b1, 64'd1, 64'd1, ST_OK));
    rows.push_back(fraction_row(64'd0, 64'd1, 1'b1, '0, '0, ST_NO_INDEX));
    rows.push_back(fraction_row(64'd1, 64'd0, 1'b1, '0, '0, ST_NO_INDEX));
    rows.push_back(fraction_row(64'd0, 64'd0, 1'b1, '0, '0, ST_NO_INDEX));
    rows.push_back(fraction_row(64'd0, '1, 1'b1, '0, '0, ST_NO_INDEX));
    rows.push_back(fraction_row(64'd2, 64'd4, 1'b1, '0, '0, ST_NOT_REDUCED));
    rows.push_back(fraction_row(64'd6, 64'd4, 1'b1, '0, '0, ST_NOT_REDUCED));
    rows.push_back(fraction_row('1, '1, 1'b1, '0, '0, ST_NOT_REDUCED));
    rows.push_back(fraction_row(64'd1, 64'd2, 1'b1, 64'd2, 64'd2, ST_OK));
    rows.push_back(fraction_row(64'd2, 64'd1, 1'b1, 64'd3, 64'd3, ST_OK));
    rows.push_back(fraction_row(64'd63, 64'd1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF,
                                64'h7FFF_FFFF_FFFF_FFFF, ST_OK));
    rows.push_back(fraction_row(64'd64, 64'd1));
    rows.push_back(fraction_row(64'd65, 64'd1, 1'b1, '0, '0, ST_NO_INDEX));
    rows.push_back(fraction_row(64'd1, 64'd64));
    rows.push_back(fraction_row(64'd1, 64'd65, 1'b1, '0, '0, ST_NO_INDEX));
    rows.push_back(fraction_row('1, 64'd1, 1'b1, '0, '0, ST_NO_INDEX));
    rows.push_back(fraction_row(64'd1, '1, 1'b1, '0, '0, ST_NO_INDEX));
    rows.push_back(fraction_row(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF));
    rows.push_back(fraction_row(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000));
    rows.push_back(fraction_row(64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF));
    rows.push_back(fraction_row(64'd12200160415121876738, 64'd7540113804746346429));
    rows.push_back(fraction_row(64'd55, 64'd34));
    rows.push_back(fraction_row(64'd3, 64'd2));
    rows.push_back(fraction_row(64'd2, 64'd3));
    rows.push_back(fraction_row(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) offer_fraction(rows[i]);

    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) wait_until_drained();
      kind = $urandom_range(99, 0);
      if (kind < 65) begin
        // Walk down the Calkin-Wilf tree along a random path to get a reduced fraction; some get scaled.
        depth = $urandom_range(63, 0);
        path  = {$urandom(), $urandom()};
        num   = 64'd1;
        den   = 64'd1;
        for (int lvl = depth - 1; lvl >= 0; lvl--) begin
          if (path[lvl]) num = num + den;
          else den = num + den;
        end
        if (kind >= 55) begin
          scale = $urandom_range(1000, 2);
          num   = num * scale;
          den   = den * scale;
        end
      end else if (kind < 72) begin
        num = 64'($urandom_range(70, 1));
        den = 64'd1;
        if ($urandom_range(1, 0) == 1) begin
          den = num;
          num = 64'd1;
        end
      end else if (kind < 80) begin
        num = {$urandom(), $urandom()};
        den = {$urandom(), $urandom()};
        if ($urandom_range(1, 0) == 1) num = '0;
        else den = '0;
      end else begin
        num = {$urandom(), $urandom()} >> $urandom_range(63, 0);
        den = {$urandom(), $urandom()} >> $urandom_range(63, 0);
      end
      item = fraction_row(num, den);
      offer_fraction(item);
    end

    wait_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
